FILE: design/sorted_list_merger_defines.svh
// ---------------------------------------------------------------------------
// sorted_list_merger_defines: assertion macros
// Concurrent check macros for the sorted_list_merger design file.
// ---------------------------------------------------------------------------
`ifndef SORTED_LIST_MERGER_DEFINES_SVH
`define SORTED_LIST_MERGER_DEFINES_SVH

// same-cycle implication, reset masks the check
`define SLM_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sorted_list_merger check failed");

// next-cycle implication, reset masks the check
`define SLM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sorted_list_merger check failed");

`endif

FILE: design/slm_pkg.sv
// ---------------------------------------------------------------------------
// slm_pkg
// Types and constants shared by the sorted list merger.
// ---------------------------------------------------------------------------
package slm_pkg;

	localparam int LIST_DEPTH = 32;
	localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
	localparam int VAL_W      = 32;
	localparam int OP_W       = 2;

	localparam logic [OP_W-1:0] OP_LOAD_FIRST  = 2'd0;
	localparam logic [OP_W-1:0] OP_LOAD_SECOND = 2'd1;
	localparam logic [OP_W-1:0] OP_RUN         = 2'd2;

	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(LIST_DEPTH);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_CMP
	} state_t;

endpackage

FILE: design/slm_ram.sv
// ---------------------------------------------------------------------------
// slm_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ---------------------------------------------------------------------------
module slm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                                           clk,
	input  logic                                           we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                               wdata,
	input  logic                                           re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                               rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		// read data holds while re is low
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: design/sorted_list_merger.sv
// ---------------------------------------------------------------------------
// sorted_list_merger
// Two-way merge of two loaded ascending lists of signed 32-bit values.
// ---------------------------------------------------------------------------
// Items with opcode 0 or 1 in tuser append tdata to the first or second list
// (one item per cycle, dropped when that list already holds LIST_DEPTH
// entries). An item with opcode 2 starts a run: the two lists are merged in
// ascending signed order, ties going to the first list, and each element
// leaves as one output item with its source list in tuser and tlast on the
// final one; the run empties both lists, and a run on two empty lists gives
// nothing. Each list lives in its own RAM with registered read, and every
// merge step reads both heads and then compares them, giving one output item
// per step and waiting while the output side stalls. No input item is taken
// while a run is going. Opcode 3 is accepted and ignored.
module sorted_list_merger (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [slm_pkg::VAL_W-1:0] s_tdata,  // [31:0] value
	input  logic [slm_pkg::OP_W-1:0]  s_tuser,  // [1:0] opcode
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [slm_pkg::VAL_W-1:0] m_tdata,  // [31:0] merged_value
	output logic                     m_tuser,  // [0] source_list
	output logic                     m_tlast
);

	import slm_pkg::*;

	`include "sorted_list_merger_defines.svh"

	state_t state_q, state_d;

	logic [CNT_W-1:0] first_count_q, second_count_q;
	logic [CNT_W-1:0] n_q, m_q;
	logic [CNT_W-1:0] i_q, j_q;

	logic             in_acc;
	logic             run_go;
	logic             rd_en;
	logic             out_load;
	logic             take_first;
	logic             is_last;
	logic             out_free;

	logic [VAL_W-1:0] first_rdata, second_rdata;
	logic             we_first, we_second;

	assign in_acc    = s_tvalid && s_tready;
	assign we_first  = in_acc && (s_tuser == OP_LOAD_FIRST) && (first_count_q < CNT_FULL);
	assign we_second = in_acc && (s_tuser == OP_LOAD_SECOND) && (second_count_q < CNT_FULL);
	assign out_free  = !m_tvalid || m_tready;

	// head choice: first list wins on a tie or when the second is used up
	assign take_first = (i_q < n_q) &&
		((j_q >= m_q) || ($signed(first_rdata) <= $signed(second_rdata)));
	assign is_last = ({1'b0, i_q} + {1'b0, j_q} + (CNT_W+1)'(1)) ==
		({1'b0, n_q} + {1'b0, m_q});

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		rd_en    = 1'b0;
		out_load = 1'b0;
		run_go   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				// ready is high here, so valid alone marks the accepted item
				if (s_tvalid && (s_tuser == OP_RUN) &&
					((first_count_q != '0) || (second_count_q != '0))) begin
					run_go  = 1'b1;
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				rd_en   = 1'b1;
				state_d = ST_CMP;
			end
			ST_CMP: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = is_last ? ST_IDLE : ST_READ;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_count_q  <= '0;
			second_count_q <= '0;
			n_q            <= '0;
			m_q            <= '0;
			i_q            <= '0;
			j_q            <= '0;
			m_tvalid       <= 1'b0;
		end else begin
			if (we_first) begin
				first_count_q <= first_count_q + CNT_W'(1);
			end
			if (we_second) begin
				second_count_q <= second_count_q + CNT_W'(1);
			end
			if (run_go) begin
				n_q            <= first_count_q;
				m_q            <= second_count_q;
				i_q            <= '0;
				j_q            <= '0;
				first_count_q  <= '0;
				second_count_q <= '0;
			end
			if (out_load) begin
				if (take_first) begin
					i_q <= i_q + CNT_W'(1);
				end else begin
					j_q <= j_q + CNT_W'(1);
				end
			end
			if (out_load) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata <= take_first ? first_rdata : second_rdata;
			m_tuser <= !take_first;
			m_tlast <= is_last;
		end
	end

	// write port takes the load address, read port the run heads
	slm_ram #(
		.WIDTH (VAL_W),
		.DEPTH (LIST_DEPTH)
	) u_first_ram (
		.clk   (clk),
		.we    (we_first),
		.waddr (first_count_q[IDX_W-1:0]),
		.wdata (s_tdata),
		.re    (rd_en),
		.raddr (i_q[IDX_W-1:0]),
		.rdata (first_rdata)
	);

	slm_ram #(
		.WIDTH (VAL_W),
		.DEPTH (LIST_DEPTH)
	) u_second_ram (
		.clk   (clk),
		.we    (we_second),
		.waddr (second_count_q[IDX_W-1:0]),
		.wdata (s_tdata),
		.re    (rd_en),
		.raddr (j_q[IDX_W-1:0]),
		.rdata (second_rdata)
	);

	`SLM_ASSERT_IMPL(a_count_bound, 1'b1, (first_count_q <= CNT_FULL) && (second_count_q <= CNT_FULL))
	`SLM_ASSERT_IMPL(a_work_left, (state_q == ST_READ) || (state_q == ST_CMP), (i_q < n_q) || (j_q < m_q))
	`SLM_ASSERT_NEXT(a_last_ends_run, out_load && is_last, (state_q == ST_IDLE) && m_tlast)
	`SLM_ASSERT_NEXT(a_run_clears, run_go, (first_count_q == '0) && (second_count_q == '0) && (state_q == ST_READ))

endmodule

FILE: tb/sorted_list_merger_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sorted_list_merger_tb
// Loads both lists through the input stream, fires merge runs and checks
// every merged item against an in-bench model of the two lists or a typed
// expectation. A short table covers extremes, ties, ignored opcodes and empty
// runs. Random jobs follow, some of them overfilling a list, with bursty
// input and a stalling output side.
// ---------------------------------------------------------------------------
module sorted_list_merger_tb;
	import slm_pkg::*;

	localparam logic [OP_W-1:0] OP_IGNORED = 2'd3;
	localparam int REPORT_LIMIT = 10;
	localparam int RANDOM_ITEMS = 160;
	localparam int DRAIN_CYCLES = 20;
	localparam int TIMEOUT_NS   = 1_000_000;

	typedef struct packed {
		logic [VAL_W-1:0] value;
		logic             src;
		logic             last;
	} merged_item_t;

	typedef enum logic [1:0] {
		CHK_PREDICT,
		CHK_NOTHING,
		CHK_SINGLE
	} row_check_t;

	typedef struct {
		logic [OP_W-1:0]  op;
		logic [VAL_W-1:0] value;
		row_check_t       chk;
		merged_item_t     typed;
	} stim_row_t;

	logic             clk;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [VAL_W-1:0] s_tdata;  // [31:0] value
	logic [OP_W-1:0]  s_tuser;  // [1:0] opcode
	logic             m_tvalid;
	logic             m_tready;
	logic [VAL_W-1:0] m_tdata;  // [31:0] merged_value
	logic             m_tuser;  // [0] source_list
	logic             m_tlast;

	sorted_list_merger dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	logic [VAL_W-1:0] first_list[$];
	logic [VAL_W-1:0] second_list[$];
	merged_item_t     merged_expected[$];
	stim_row_t        directed_rows[$];
	int               mismatch_count;
	int               burst_left;
	logic [15:0]      stall_pattern;
	int               stall_phase;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("sorted_list_merger_tb failed");
		$finish;
	end

	// list model: appends, merge with ties to the first list, clear on run
	task automatic model_item(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] val,
			input bit record);
		int i;
		int j;
		merged_item_t r;
		i = 0;
		j = 0;
		case (op)
			OP_LOAD_FIRST: begin
				if (first_list.size() < LIST_DEPTH) first_list.push_back(val);
			end
			OP_LOAD_SECOND: begin
				if (second_list.size() < LIST_DEPTH) second_list.push_back(val);
			end
			OP_RUN: begin
				while (i < first_list.size() || j < second_list.size()) begin
					if (j >= second_list.size() || (i < first_list.size() &&
							$signed(first_list[i]) <= $signed(second_list[j]))) begin
						r.value = first_list[i];
						r.src   = 1'b0;
						i++;
					end else begin
						r.value = second_list[j];
						r.src   = 1'b1;
						j++;
					end
					r.last = (i == first_list.size()) && (j == second_list.size());
					if (record) merged_expected.push_back(r);
				end
				first_list.delete();
				second_list.delete();
			end
			default: ;
		endcase
	endtask

	// bursts of random length, random gaps between them
	task automatic send_item(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] val);
		int gap;
		bit taken;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 6);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= val;
		s_tuser  <= op;
		// sample ready mid-cycle, the item goes at the following rising edge
		do begin
			@(negedge clk);
			taken = s_tready;
			@(posedge clk);
		end while (!taken);
	endtask

	task automatic add_row(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] val,
			input row_check_t chk, input merged_item_t typed);
		stim_row_t row;
		row.op    = op;
		row.value = val;
		row.chk   = chk;
		row.typed = typed;
		directed_rows.push_back(row);
	endtask

	// ascending walk that holds at the top instead of wrapping
	function automatic logic [VAL_W-1:0] step_up(input logic [VAL_W-1:0] cur,
			input int unsigned step_max);
		logic [VAL_W-1:0] nxt;
		nxt = cur + $urandom_range(0, step_max);
		if ($signed(nxt) < $signed(cur)) nxt = cur;
		return nxt;
	endfunction

	// load two lists in random interleaving, then usually run the merge
	task automatic merge_job(input int n_first, input int n_second, ref int sent);
		logic [VAL_W-1:0] cur_a;
		logic [VAL_W-1:0] cur_b;
		logic [VAL_W-1:0] v;
		logic [OP_W-1:0]  op;
		int unsigned      step_max;
		bit               scramble;
		int               ia;
		int               ib;
		scramble = ($urandom_range(0, 9) == 0);
		step_max = 1 << $urandom_range(0, 24);
		case ($urandom_range(0, 7))
			0:       cur_a = {1'b1, {(VAL_W-1){1'b0}}};
			1:       cur_a = {1'b0, {(VAL_W-1){1'b1}}} - $urandom_range(0, 64);
			default: cur_a = $urandom;
		endcase
		cur_b = cur_a;
		ia = 0;
		ib = 0;
		while (ia < n_first || ib < n_second) begin
			if ($urandom_range(0, 11) == 0) send_item(OP_IGNORED, $urandom);
			if (ib >= n_second || (ia < n_first && $urandom_range(0, 1) == 0)) begin
				op    = OP_LOAD_FIRST;
				cur_a = scramble ? $urandom : step_up(cur_a, step_max);
				v     = cur_a;
				ia++;
			end else begin
				op    = OP_LOAD_SECOND;
				cur_b = scramble ? $urandom : step_up(cur_b, step_max);
				v     = cur_b;
				ib++;
			end
			model_item(op, v, 1'b1);
			send_item(op, v);
			sent++;
		end
		// now and then the lists carry over into the next job
		if ($urandom_range(0, 11) != 0) begin
			v = $urandom;
			model_item(OP_RUN, v, 1'b1);
			send_item(OP_RUN, v);
			sent++;
		end
	endtask

	// receiver stall pattern, reloaded every so often
	always @(posedge clk) begin
		if (stall_phase == 0) begin
			case ($urandom_range(0, 3))
				0:       stall_pattern = '1;
				1:       stall_pattern = 16'($urandom) | 16'h5555;
				2:       stall_pattern = 16'($urandom) | 16'h0001;
				default: stall_pattern = 16'($urandom & $urandom) | 16'h0001;
			endcase
		end
		m_tready <= stall_pattern[stall_phase % 16];
		stall_phase = (stall_phase + 1) % 150;
	end

	// outputs only move at rising edges, so mid-cycle values are the accepted ones
	always @(negedge clk) begin : merge_monitor
		merged_item_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (merged_expected.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT)
					$display("unexpected item: value %h source %b last %b",
						m_tdata, m_tuser, m_tlast);
			end else begin
				want = merged_expected.pop_front();
				if (m_tdata !== want.value || m_tuser !== want.src ||
						m_tlast !== want.last) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT)
						$display("mismatch: value %h/%h source %b/%b last %b/%b (exp/act)",
							want.value, m_tdata, want.src, m_tuser, want.last, m_tlast);
				end
			end
		end
	end

	initial begin
		int sent;
		merged_item_t none;
		arst_n         = 1'b0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		s_tuser        = '0;
		m_tready       = 1'b0;
		stall_pattern  = '1;
		stall_phase    = 0;
		mismatch_count = 0;
		burst_left     = 0;
		sent           = 0;
		none           = '0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		add_row(OP_RUN, 32'h0, CHK_NOTHING, none);
		add_row(OP_LOAD_FIRST, 32'h8000_0000, CHK_PREDICT, none);
		add_row(OP_RUN, 32'h0, CHK_SINGLE, '{32'h8000_0000, 1'b0, 1'b1});
		add_row(OP_LOAD_SECOND, 32'h7fff_ffff, CHK_PREDICT, none);
		add_row(OP_RUN, 32'hffff_ffff, CHK_SINGLE, '{32'h7fff_ffff, 1'b1, 1'b1});
		// ties go to the first list
		add_row(OP_LOAD_FIRST, 32'd5, CHK_PREDICT, none);
		add_row(OP_LOAD_SECOND, 32'd5, CHK_PREDICT, none);
		add_row(OP_LOAD_SECOND, 32'd5, CHK_PREDICT, none);
		add_row(OP_RUN, 32'h0, CHK_PREDICT, none);
		add_row(OP_IGNORED, 32'hffff_ffff, CHK_PREDICT, none);
		add_row(OP_IGNORED, 32'h0, CHK_PREDICT, none);
		add_row(OP_RUN, 32'h0, CHK_NOTHING, none);
		add_row(OP_LOAD_FIRST, 32'hffff_ffff, CHK_PREDICT, none);
		add_row(OP_LOAD_FIRST, 32'h0, CHK_PREDICT, none);
		add_row(OP_RUN, 32'h0, CHK_PREDICT, none);
		// unsorted first list
		add_row(OP_LOAD_FIRST, 32'd10, CHK_PREDICT, none);
		add_row(OP_LOAD_FIRST, 32'd3, CHK_PREDICT, none);
		add_row(OP_LOAD_SECOND, 32'd7, CHK_PREDICT, none);
		add_row(OP_RUN, 32'h0, CHK_PREDICT, none);
		add_row(OP_LOAD_FIRST, 32'h7fff_ffff, CHK_PREDICT, none);
		add_row(OP_LOAD_SECOND, 32'h8000_0000, CHK_PREDICT, none);
		add_row(OP_RUN, 32'h0, CHK_PREDICT, none);

		foreach (directed_rows[k]) begin
			model_item(directed_rows[k].op, directed_rows[k].value,
				directed_rows[k].chk == CHK_PREDICT);
			if (directed_rows[k].chk == CHK_SINGLE)
				merged_expected.push_back(directed_rows[k].typed);
			send_item(directed_rows[k].op, directed_rows[k].value);
		end

		// start with both lists overfilled, then mostly short jobs
		merge_job(LIST_DEPTH + 2, LIST_DEPTH + 1, sent);
		while (sent < RANDOM_ITEMS) begin
			if ($urandom_range(0, 15) == 0)
				merge_job($urandom_range(LIST_DEPTH - 2, LIST_DEPTH + 4),
					$urandom_range(0, LIST_DEPTH + 4), sent);
			else
				merge_job($urandom_range(0, 6), $urandom_range(0, 6), sent);
		end
		// flush whatever a skipped run left behind
		model_item(OP_RUN, 32'h0, 1'b1);
		send_item(OP_RUN, 32'h0);
		s_tvalid <= 1'b0;

		while (merged_expected.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (merged_expected.size() != 0) begin
			mismatch_count++;
			$display("%0d merged items never arrived", merged_expected.size());
		end
		if (mismatch_count == 0)
			$display("sorted_list_merger_tb passed");
		else
			$display("sorted_list_merger_tb failed");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+design
design/slm_pkg.sv
design/slm_ram.sv
design/sorted_list_merger.sv
tb/sorted_list_merger_tb.sv
